// ===== design/itp_pkg.sv =====
// Shared types, constants and lookup functions for the infix-to-postfix converter.
`timescale 1ns / 1ps

package itp_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W       = $clog2(STACK_DEPTH);

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [2:0] {
		OP_OPEN = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4
	} op_code_t;

	typedef enum logic [1:0] {
		K_SYM = 2'd0,
		K_END = 2'd1,
		K_ERR = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		E_NONE      = 2'd0,
		E_OVERFLOW  = 2'd1,
		E_UNMATCHED = 2'd2
	} err_t;

	typedef struct packed {
		logic     push;
		logic     pop;
		op_code_t code;
	} stack_ctrl_t;

	typedef struct packed {
		logic     empty;
		logic     full;
		op_code_t top;
	} stack_stat_t;

	function automatic logic [7:0] op_char(input op_code_t c);
		logic [7:0] r;
		unique case (c)
			OP_ADD:  r = CH_PLUS;
			OP_SUB:  r = CH_MINUS;
			OP_MUL:  r = CH_STAR;
			OP_DIV:  r = CH_SLASH;
			default: r = CH_OPEN;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] op_prec(input op_code_t c);
		logic [1:0] r;
		case (c)
			OP_ADD, OP_SUB: r = 2'd1;
			OP_MUL, OP_DIV: r = 2'd2;
			default:        r = 2'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== design/itp_op_stack.sv =====
// Operator stack: memory with a registered copy of the top entry and a fill count.
`timescale 1ns / 1ps

module itp_op_stack (
	input  logic                clk,
	input  logic                arst_n,
	input  itp_pkg::stack_ctrl_t ctrl,
	output itp_pkg::stack_stat_t stat
);

	itp_pkg::op_code_t                  mem_q [itp_pkg::STACK_DEPTH];
	itp_pkg::op_code_t                  top_q;
	logic [itp_pkg::CNT_W-1:0]          cnt_q;
	logic [itp_pkg::CNT_W-1:0]          below_top;

	// entry under the current top; only consumed when the count is at least two
	assign below_top = cnt_q - itp_pkg::CNT_W'(2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.push) begin
			cnt_q <= cnt_q + itp_pkg::CNT_W'(1);
		end else if (ctrl.pop) begin
			cnt_q <= cnt_q - itp_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem_q[cnt_q[itp_pkg::IDX_W-1:0]] <= ctrl.code;
			top_q                            <= ctrl.code;
		end else if (ctrl.pop) begin
			top_q <= mem_q[below_top[itp_pkg::IDX_W-1:0]];
		end
	end

	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH));
	assign stat.top   = top_q;

endmodule

// ===== design/infix_to_postfix_converter.sv =====
// Infix-to-postfix converter top level: input decode, pop/push sequencer, result staging.
//
//  channel  signals                                  direction
//  in       in_valid in_ready symbol end_flag        into block
//  out      out_valid out_ready out_symbol kind      out of block
//           error_code last
//
// An accepted character passes an accept step and then sequencer steps, each of
// which does at most one stack pop or push and gives at most one result. A final
// error item or end marker that follows emitted operators needs a flush step to
// drain the pending slot. The sequencer pops one stack entry per cycle unless the
// output stalls; each result waits one slot in a pending register so that the
// final result can carry last.
// A stalled output holds the sequencer; in_ready stays low until the item is done.
// Reset clears the stack count, the sequencer and both valid flags.
`timescale 1ns / 1ps

module infix_to_postfix_converter (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] symbol,
	input  logic       end_flag,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_symbol,
	output logic [1:0] kind,
	output logic [1:0] error_code,
	output logic       last
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RUN   = 3'b010,
		ST_FLUSH = 3'b100
	} state_t;

	typedef enum logic [2:0] {
		M_END,
		M_ALNUM,
		M_OPEN,
		M_CLOSE,
		M_OPER,
		M_DROP
	} mode_t;

	typedef struct packed {
		logic [7:0]     sym;
		itp_pkg::kind_t kind;
		itp_pkg::err_t  err;
	} res_t;

	state_t              state_q;
	mode_t               mode_q, mode_d;
	logic [7:0]          sym_q;
	itp_pkg::op_code_t   code_q, code_d;

	res_t                pend_q;
	logic                pend_v_q;
	res_t                out_q;
	logic                out_last_q;
	logic                out_valid_q;

	itp_pkg::stack_ctrl_t st_ctrl;
	itp_pkg::stack_stat_t st_stat;

	res_t                res;
	logic                res_v;
	logic                fin;
	logic                want_push;
	logic                want_pop;
	logic                op_free;
	logic                go;
	logic                accept;
	logic                out_load;

	itp_op_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (st_ctrl),
		.stat   (st_stat)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign op_free  = !out_valid_q || out_ready;

	// input classification
	always_comb begin
		code_d = itp_pkg::OP_ADD;
		if (end_flag) begin
			mode_d = M_END;
		end else if ((symbol >= 8'h41 && symbol <= 8'h5A) ||
		             (symbol >= 8'h61 && symbol <= 8'h7A) ||
		             (symbol >= 8'h30 && symbol <= 8'h39)) begin
			mode_d = M_ALNUM;
		end else begin
			case (symbol)
				itp_pkg::CH_OPEN:  mode_d = M_OPEN;
				itp_pkg::CH_CLOSE: mode_d = M_CLOSE;
				itp_pkg::CH_PLUS:  mode_d = M_OPER;
				itp_pkg::CH_MINUS: begin
					mode_d = M_OPER;
					code_d = itp_pkg::OP_SUB;
				end
				itp_pkg::CH_STAR: begin
					mode_d = M_OPER;
					code_d = itp_pkg::OP_MUL;
				end
				itp_pkg::CH_SLASH: begin
					mode_d = M_OPER;
					code_d = itp_pkg::OP_DIV;
				end
				default: mode_d = M_DROP;
			endcase
		end
		// '(' goes on the stack as its own code
		if (!end_flag && symbol == itp_pkg::CH_OPEN) begin
			code_d = itp_pkg::OP_OPEN;
		end
	end

	// one sequencer step: at most one pop or push and at most one result
	always_comb begin
		res       = '{sym: 8'h00, kind: itp_pkg::K_SYM, err: itp_pkg::E_NONE};
		res_v     = 1'b0;
		fin       = 1'b0;
		want_push = 1'b0;
		want_pop  = 1'b0;
		unique case (mode_q)
			M_END: begin
				if (!st_stat.empty) begin
					res.sym  = itp_pkg::op_char(st_stat.top);
					res_v    = 1'b1;
					want_pop = 1'b1;
				end else begin
					res.kind = itp_pkg::K_END;
					res_v    = 1'b1;
					fin      = 1'b1;
				end
			end
			M_ALNUM: begin
				res.sym = sym_q;
				res_v   = 1'b1;
				fin     = 1'b1;
			end
			M_CLOSE: begin
				if (st_stat.empty) begin
					res.kind = itp_pkg::K_ERR;
					res.err  = itp_pkg::E_UNMATCHED;
					res_v    = 1'b1;
					fin      = 1'b1;
				end else if (st_stat.top == itp_pkg::OP_OPEN) begin
					want_pop = 1'b1;
					fin      = 1'b1;
				end else begin
					res.sym  = itp_pkg::op_char(st_stat.top);
					res_v    = 1'b1;
					want_pop = 1'b1;
				end
			end
			M_OPEN, M_OPER: begin
				if (mode_q == M_OPER && !st_stat.empty &&
				    itp_pkg::op_prec(code_q) <= itp_pkg::op_prec(st_stat.top)) begin
					res.sym  = itp_pkg::op_char(st_stat.top);
					res_v    = 1'b1;
					want_pop = 1'b1;
				end else if (st_stat.full) begin
					res.kind = itp_pkg::K_ERR;
					res.err  = itp_pkg::E_OVERFLOW;
					res_v    = 1'b1;
					fin      = 1'b1;
				end else begin
					want_push = 1'b1;
					fin       = 1'b1;
				end
			end
			default: begin
				fin = 1'b1;
			end
		endcase
	end

	// a final result needs the output slot; any other step only when pending must move
	assign go = (res_v && fin) ? op_free : (!pend_v_q || op_free);

	// output register takes a new result this cycle
	assign out_load = ((state_q == ST_RUN) && go && (res_v || fin) &&
	                   (pend_v_q || (res_v && fin))) ||
	                  ((state_q == ST_FLUSH) && op_free);

	always_comb begin
		st_ctrl.push = (state_q == ST_RUN) && go && want_push;
		st_ctrl.pop  = (state_q == ST_RUN) && go && want_pop;
		st_ctrl.code = code_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (go) begin
						if (res_v && fin) begin
							if (pend_v_q) begin
								pend_v_q <= 1'b1;
								state_q  <= ST_FLUSH;
							end else begin
								state_q <= ST_IDLE;
							end
						end else if (res_v) begin
							pend_v_q <= 1'b1;
						end else if (fin) begin
							pend_v_q <= 1'b0;
							state_q  <= ST_IDLE;
						end
					end
				end
				ST_FLUSH: begin
					if (op_free) begin
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode_d;
			sym_q  <= symbol;
			code_q <= code_d;
		end
		if (state_q == ST_RUN && go) begin
			if (res_v && fin && !pend_v_q) begin
				out_q      <= res;
				out_last_q <= 1'b1;
			end else if (pend_v_q && (res_v || fin)) begin
				out_q      <= pend_q;
				out_last_q <= !res_v;
			end
			if (res_v) begin
				pend_q <= res;
			end
		end else if (state_q == ST_FLUSH && op_free) begin
			out_q      <= pend_q;
			out_last_q <= 1'b1;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_symbol = out_q.sym;
	assign kind       = out_q.kind;
	assign error_code = out_q.err;
	assign last       = out_last_q;

endmodule

// ===== design/itp_checker.sv =====
// Port-level checks for the infix-to-postfix converter, bound to the top level.
`timescale 1ns / 1ps

module itp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_symbol,
	input logic [1:0] kind,
	input logic [1:0] error_code,
	input logic       last
);

	// a stalled result holds still
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_symbol) && $stable(kind) &&
		$stable(error_code) && $stable(last))
		else $error("result changed while stalled");

	// the block is busy right after taking a request
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after accept");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == itp_pkg::K_END |-> last)
		else $error("end marker without last");

	a_sym_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != itp_pkg::K_SYM |-> out_symbol == 8'h00)
		else $error("nonzero symbol on marker or error");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != itp_pkg::K_ERR |-> error_code == itp_pkg::E_NONE)
		else $error("error code on non-error result");

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.out_symbol (out_symbol),
	.kind       (kind),
	.error_code (error_code),
	.last       (last)
);

// ===== tb/tb.sv =====
// Self-checking testbench for infix_to_postfix_converter: shunting-yard predictor and scoreboard.
`timescale 1ns / 1ps

module tb;

	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic [7:0]     out_symbol;
		itp_pkg::kind_t kind;
		itp_pkg::err_t  error_code;
		logic           last;
	} postfix_item_t;

	// Keeps its own operator stack and queues the postfix output of each request.
	class postfix_scoreboard;
		postfix_item_t     expected_postfix[$];
		itp_pkg::op_code_t op_stack[itp_pkg::STACK_DEPTH];
		int                stack_fill;
		int                mismatches;

		function new();
			stack_fill = 0;
			mismatches = 0;
		endfunction

		function void emit(logic [7:0] ch, itp_pkg::kind_t k, itp_pkg::err_t e);
			postfix_item_t r;
			r.out_symbol = ch;
			r.kind = k;
			r.error_code = e;
			r.last = 1'b0;
			expected_postfix.push_back(r);
		endfunction

		function logic [7:0] op_to_char(itp_pkg::op_code_t c);
			case (c)
				itp_pkg::OP_ADD: return itp_pkg::CH_PLUS;
				itp_pkg::OP_SUB: return itp_pkg::CH_MINUS;
				itp_pkg::OP_MUL: return itp_pkg::CH_STAR;
				itp_pkg::OP_DIV: return itp_pkg::CH_SLASH;
				default:         return itp_pkg::CH_OPEN;
			endcase
		endfunction

		function int rank(itp_pkg::op_code_t c);
			case (c)
				itp_pkg::OP_ADD, itp_pkg::OP_SUB: return 1;
				itp_pkg::OP_MUL, itp_pkg::OP_DIV: return 2;
				default:                          return 0;
			endcase
		endfunction

		function void push_op(itp_pkg::op_code_t c);
			if (stack_fill >= itp_pkg::STACK_DEPTH) begin
				emit(8'h00, itp_pkg::K_ERR, itp_pkg::E_OVERFLOW);
			end else begin
				op_stack[stack_fill] = c;
				stack_fill++;
			end
		endfunction

		function void predict_postfix(logic [7:0] ch, logic endf);
			int                start_n;
			itp_pkg::op_code_t code;
			bit                matched;
			start_n = expected_postfix.size();
			if (endf) begin
				while (stack_fill > 0) begin
					stack_fill--;
					emit(op_to_char(op_stack[stack_fill]), itp_pkg::K_SYM, itp_pkg::E_NONE);
				end
				emit(8'h00, itp_pkg::K_END, itp_pkg::E_NONE);
			end else if ((ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z") ||
					(ch >= "0" && ch <= "9")) begin
				emit(ch, itp_pkg::K_SYM, itp_pkg::E_NONE);
			end else if (ch == itp_pkg::CH_OPEN) begin
				push_op(itp_pkg::OP_OPEN);
			end else if (ch == itp_pkg::CH_CLOSE) begin
				matched = 1'b0;
				while (stack_fill > 0 && !matched) begin
					stack_fill--;
					if (op_stack[stack_fill] == itp_pkg::OP_OPEN)
						matched = 1'b1;
					else
						emit(op_to_char(op_stack[stack_fill]), itp_pkg::K_SYM,
							itp_pkg::E_NONE);
				end
				if (!matched)
					emit(8'h00, itp_pkg::K_ERR, itp_pkg::E_UNMATCHED);
			end else if (ch == itp_pkg::CH_PLUS || ch == itp_pkg::CH_MINUS ||
					ch == itp_pkg::CH_STAR || ch == itp_pkg::CH_SLASH) begin
				case (ch)
					itp_pkg::CH_PLUS:  code = itp_pkg::OP_ADD;
					itp_pkg::CH_MINUS: code = itp_pkg::OP_SUB;
					itp_pkg::CH_STAR:  code = itp_pkg::OP_MUL;
					default:           code = itp_pkg::OP_DIV;
				endcase
				while (stack_fill > 0 && rank(code) <= rank(op_stack[stack_fill - 1])) begin
					stack_fill--;
					emit(op_to_char(op_stack[stack_fill]), itp_pkg::K_SYM, itp_pkg::E_NONE);
				end
				push_op(code);
			end
			if (expected_postfix.size() > start_n)
				expected_postfix[expected_postfix.size() - 1].last = 1'b1;
		endfunction

		function void check_result(postfix_item_t got);
			postfix_item_t want;
			if (expected_postfix.size() == 0) begin
				$display("%0t: unexpected result: out_symbol %h kind %0d error_code %0d last %b",
					$time, got.out_symbol, got.kind, got.error_code, got.last);
				mismatches++;
				return;
			end
			want = expected_postfix.pop_front();
			if (got.out_symbol !== want.out_symbol) begin
				$display("%0t: out_symbol expected %h actual %h",
					$time, want.out_symbol, got.out_symbol);
				mismatches++;
			end
			if (got.kind !== want.kind) begin
				$display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
				mismatches++;
			end
			if (got.error_code !== want.error_code) begin
				$display("%0t: error_code expected %0d actual %0d",
					$time, want.error_code, got.error_code);
				mismatches++;
			end
			if (got.last !== want.last) begin
				$display("%0t: last expected %b actual %b", $time, want.last, got.last);
				mismatches++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] symbol = 8'h00;
	logic       end_flag = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_symbol;
	logic [1:0] kind;
	logic [1:0] error_code;
	logic       last;

	postfix_scoreboard sb;
	postfix_item_t     seen_result;
	bit                steady = 1'b0;
	int                cycle_count = 0;
	int                random_items = 0;
	logic [7:0]        expr_chars[$];
	logic [7:0]        op_chars[4] = '{itp_pkg::CH_PLUS, itp_pkg::CH_MINUS,
		itp_pkg::CH_STAR, itp_pkg::CH_SLASH};

	infix_to_postfix_converter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.symbol(symbol),
		.end_flag(end_flag),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_symbol(out_symbol),
		.kind(kind),
		.error_code(error_code),
		.last(last)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("infix_to_postfix_converter test failed");
			$finish;
		end
	end

	function automatic bit take_gap();
		return !steady && ($urandom_range(0, 99) < 26);
	endfunction

	always @(negedge clk) begin
		out_ready <= !take_gap();
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen_result.out_symbol = out_symbol;
			seen_result.kind = itp_pkg::kind_t'(kind);
			seen_result.error_code = itp_pkg::err_t'(error_code);
			seen_result.last = last;
			sb.check_result(seen_result);
		end
	end

	task automatic drive_request(input logic [7:0] ch, input logic endf);
		@(negedge clk);
		while (take_gap()) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		symbol = ch;
		end_flag = endf;
		do @(posedge clk); while (!in_ready);
		sb.predict_postfix(ch, endf);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			drive_request(s[i], 1'b0);
	endtask

	// Mostly well-formed expressions with random operands and nesting; some get
	// noise bytes, stray ')' or left-open '(' mixed in.
	task automatic make_expression();
		int terms;
		int open_cnt;
		int pos;
		expr_chars.delete();
		terms = $urandom_range(1, 8);
		open_cnt = 0;
		for (int t = 0; t < terms; t++) begin
			if (t > 0)
				expr_chars.push_back(op_chars[$urandom_range(0, 3)]);
			while ($urandom_range(0, 3) == 0 && open_cnt < 40) begin
				expr_chars.push_back(itp_pkg::CH_OPEN);
				open_cnt++;
			end
			case ($urandom_range(0, 2))
				0:       expr_chars.push_back(8'("A" + $urandom_range(0, 25)));
				1:       expr_chars.push_back(8'("a" + $urandom_range(0, 25)));
				default: expr_chars.push_back(8'("0" + $urandom_range(0, 9)));
			endcase
			while (open_cnt > 0 && $urandom_range(0, 2) == 0) begin
				expr_chars.push_back(itp_pkg::CH_CLOSE);
				open_cnt--;
			end
			if ($urandom_range(0, 5) == 0)
				expr_chars.push_back(itp_pkg::CH_SPACE);
		end
		if ($urandom_range(0, 3) != 0) begin
			while (open_cnt > 0) begin
				expr_chars.push_back(itp_pkg::CH_CLOSE);
				open_cnt--;
			end
		end
		if ($urandom_range(0, 3) == 0) begin
			pos = $urandom_range(0, expr_chars.size());
			expr_chars.insert(pos, 8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 7) == 0) begin
			pos = $urandom_range(0, expr_chars.size());
			expr_chars.insert(pos, itp_pkg::CH_CLOSE);
		end
	endtask

	initial begin
		sb = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// end with empty stack, range edges, dropped bytes, unmatched ')'
		drive_request(8'hFF, 1'b1);
		send_text("AZaz09");
		drive_request(8'h00, 1'b0);
		drive_request(8'hFF, 1'b0);
		send_text(" )");
		// all operators, higher precedence pop
		send_text("(a+b)*c-d/e");
		drive_request(8'h00, 1'b1);
		// operator popped by unmatched ')', then open '(' left for the flush
		send_text("x+)((a");
		drive_request(8'h55, 1'b1);
		// fill the stack, then overflow with an operator and with '('
		for (int i = 0; i < itp_pkg::STACK_DEPTH; i++)
			drive_request(itp_pkg::CH_OPEN, 1'b0);
		send_text("+(");
		drive_request(8'hAA, 1'b1);

		while (random_items < 385) begin
			steady = (random_items >= 150 && random_items < 260);
			make_expression();
			foreach (expr_chars[i]) begin
				drive_request(expr_chars[i], 1'b0);
				random_items++;
			end
			drive_request(8'($urandom_range(0, 255)), 1'b1);
			random_items++;
		end
		steady = 1'b0;
		@(negedge clk);
		in_valid = 1'b0;

		while (sb.expected_postfix.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.mismatches == 0)
			$display("infix_to_postfix_converter test passed");
		else
			$display("infix_to_postfix_converter test failed");
		$finish;
	end

endmodule
